@@ rtl/tpb_pkg.sv @@
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types, register codes, reset values and helpers for the text page
// breaker.
// ----------------------------------------------------------------------------
`default_nettype none

package tpb_pkg;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 14;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LINE_WIDTH     = 3'd0,
    REG_BREAK_SLACK    = 3'd1,
    REG_NARROW_ADVANCE = 3'd2,
    REG_WIDE_ADVANCE   = 3'd3,
    REG_LINES_PER_PAGE = 3'd4,
    REG_PAGE_LIMIT     = 3'd5
  } cfg_reg_t;

  localparam logic [9:0]  LINE_WIDTH_RESET     = 10'd368;
  localparam logic [7:0]  BREAK_SLACK_RESET    = 8'd16;
  localparam logic [7:0]  NARROW_ADVANCE_RESET = 8'd18;
  localparam logic [7:0]  WIDE_ADVANCE_RESET   = 8'd25;
  localparam logic [5:0]  LINES_PER_PAGE_RESET = 6'd7;
  localparam logic [13:0] PAGE_LIMIT_RESET     = 14'd9999;

  localparam logic [13:0] PAGE_CAP = 14'd9999;
  localparam logic [7:0]  CHAR_CR  = 8'h0D;
  localparam logic [7:0]  CHAR_LF  = 8'h0A;
  localparam int unsigned WIDE_BIT = 7;

  typedef struct packed {
    logic [9:0]  line_width;
    logic [7:0]  break_slack;
    logic [7:0]  narrow_advance;
    logic [7:0]  wide_advance;
    logic [5:0]  lines_per_page;
    logic [13:0] page_limit;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] next_page_offset;
    logic [13:0] page_count;
    logic        limit_reached;
  } result_t;

  typedef struct packed {
    logic [5:0] index;
    logic       page;
  } line_step_t;

  // Counts one line break and reports whether it completes a page.
  function automatic line_step_t line_step(input logic [5:0] index,
                                           input logic [5:0] lines_per_page);
    line_step_t r;
    r.index = index + 6'd1;
    r.page  = 1'b0;
    if (r.index >= lines_per_page) begin
      r.index = '0;
      r.page  = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tpb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tpb_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [tpb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [tpb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output      tpb_pkg::cfg_t                       cfg
);
  import tpb_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width     <= LINE_WIDTH_RESET;
      cfg.break_slack    <= BREAK_SLACK_RESET;
      cfg.narrow_advance <= NARROW_ADVANCE_RESET;
      cfg.wide_advance   <= WIDE_ADVANCE_RESET;
      cfg.lines_per_page <= LINES_PER_PAGE_RESET;
      cfg.page_limit     <= PAGE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_WIDTH:     cfg.line_width     <= cfg_data[9:0];
        REG_BREAK_SLACK:    cfg.break_slack    <= cfg_data[7:0];
        REG_NARROW_ADVANCE: cfg.narrow_advance <= cfg_data[7:0];
        REG_WIDE_ADVANCE:   cfg.wide_advance   <= cfg_data[7:0];
        REG_LINES_PER_PAGE: cfg.lines_per_page <= cfg_data[5:0];
        REG_PAGE_LIMIT:     cfg.page_limit     <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/tpb_core.sv @@
// ----------------------------------------------------------------------------
// tpb_core
// Layout state and the per-byte update: column, line and offset tracking,
// line breaks, page ends and page reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_core #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step_en,
  input  wire logic [7:0]       text_byte,
  input  wire logic             restart,
  input  wire tpb_pkg::cfg_t    cfg,
  output      tpb_pkg::result_t res,
  output      logic [13:0]      pages_done
);
  import tpb_pkg::*;

  logic [9:0]             column_pos,  column_pos_next;
  logic [5:0]             line_index,  line_index_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic                   await_trail, await_trail_next;
  logic                   swallow_break, swallow_break_next;
  logic                   pending_page_end, pending_page_end_next;
  logic [13:0]            pages_done_next;

  logic                   is_break;
  logic                   emit_req;
  logic [OFFSET_BITS-1:0] emit_offset;
  logic [10:0]            col_sum;
  logic [13:0]            limit;
  line_step_t             ls;

  assign is_break = (text_byte == CHAR_CR) || (text_byte == CHAR_LF);
  assign limit    = (cfg.page_limit > PAGE_CAP) ? PAGE_CAP : cfg.page_limit;

  always_comb begin
    column_pos_next       = column_pos;
    line_index_next       = line_index;
    byte_offset_next      = byte_offset;
    await_trail_next      = await_trail;
    swallow_break_next    = swallow_break;
    pending_page_end_next = pending_page_end;
    pages_done_next       = pages_done;
    emit_req              = 1'b0;
    emit_offset           = byte_offset;
    col_sum               = '0;
    ls                    = '0;
    res                   = '0;

    if (restart) begin
      column_pos_next       = '0;
      line_index_next       = '0;
      byte_offset_next      = '0;
      await_trail_next      = 1'b0;
      swallow_break_next    = 1'b0;
      pending_page_end_next = 1'b0;
    end

    if (swallow_break_next && is_break) begin
      // Second line end of a pair (CR or LF after CR or LF): consumed, releases a held page end.
      byte_offset_next   = byte_offset_next + OFFSET_BITS'(1);
      swallow_break_next = 1'b0;
      if (pending_page_end_next) begin
        pending_page_end_next = 1'b0;
        emit_req              = 1'b1;
        emit_offset           = byte_offset_next;
      end
    end else begin
      swallow_break_next = 1'b0;
      if (pending_page_end_next) begin
        pending_page_end_next = 1'b0;
        emit_req              = 1'b1;
        emit_offset           = byte_offset_next;
      end

      if (await_trail_next) begin
        await_trail_next = 1'b0;
        byte_offset_next = byte_offset_next + OFFSET_BITS'(1);
        col_sum = {1'b0, column_pos_next} + {3'b000, cfg.wide_advance};
        if (col_sum > {1'b0, cfg.line_width}) begin
          column_pos_next = '0;
          ls              = line_step(line_index_next, cfg.lines_per_page);
          line_index_next = ls.index;
          if (ls.page) begin
            if (emit_req) begin
              pending_page_end_next = 1'b1;
            end else begin
              emit_req    = 1'b1;
              emit_offset = byte_offset_next;
            end
          end
        end else begin
          column_pos_next = col_sum[9:0];
        end
      end else begin
        // Too little room left for another character: break before it.
        if ((column_pos_next != '0) &&
            (({1'b0, column_pos_next} + {3'b000, cfg.break_slack}) >
             {1'b0, cfg.line_width})) begin
          column_pos_next = '0;
          ls              = line_step(line_index_next, cfg.lines_per_page);
          line_index_next = ls.index;
          if (ls.page) begin
            if (emit_req) begin
              pending_page_end_next = 1'b1;
            end else begin
              emit_req    = 1'b1;
              emit_offset = byte_offset_next;
            end
          end
        end

        byte_offset_next = byte_offset_next + OFFSET_BITS'(1);

        if (text_byte[WIDE_BIT]) begin
          await_trail_next = 1'b1;
        end else if (is_break) begin
          // The page end waits one byte to see whether a pair follows.
          swallow_break_next = 1'b1;
          column_pos_next    = '0;
          ls                 = line_step(line_index_next, cfg.lines_per_page);
          line_index_next    = ls.index;
          if (ls.page) begin
            pending_page_end_next = 1'b1;
          end
        end else begin
          col_sum = {1'b0, column_pos_next} + {3'b000, cfg.narrow_advance};
          if (col_sum > {1'b0, cfg.line_width}) begin
            column_pos_next = '0;
            ls              = line_step(line_index_next, cfg.lines_per_page);
            line_index_next = ls.index;
            if (ls.page) begin
              if (emit_req) begin
                pending_page_end_next = 1'b1;
              end else begin
                emit_req    = 1'b1;
                emit_offset = byte_offset_next;
              end
            end
          end else begin
            column_pos_next = col_sum[9:0];
          end
        end
      end
    end

    if (emit_req && (pages_done < limit)) begin
      pages_done_next      = pages_done + 14'd1;
      res.valid            = 1'b1;
      res.next_page_offset = 32'(emit_offset);
      res.page_count       = pages_done_next;
      res.limit_reached    = (pages_done_next >= limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos       <= '0;
      line_index       <= '0;
      byte_offset      <= '0;
      await_trail      <= 1'b0;
      swallow_break    <= 1'b0;
      pending_page_end <= 1'b0;
      pages_done       <= '0;
    end else if (step_en) begin
      column_pos       <= column_pos_next;
      line_index       <= line_index_next;
      byte_offset      <= byte_offset_next;
      await_trail      <= await_trail_next;
      swallow_break    <= swallow_break_next;
      pending_page_end <= pending_page_end_next;
      pages_done       <= pages_done_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/text_page_breaker.sv @@
// ----------------------------------------------------------------------------
// text_page_breaker
// Splits a stream of narrow and wide text characters into pages and reports
// the byte offset at which each new page starts.
// ----------------------------------------------------------------------------
// Path: a byte on the input is held in the input register, and its result
// then loads into the result register.
// Throughput: one byte per cycle while the result side is not stalled.
// Reset: rst (synchronous) clears the layout state and page count and loads
// the register defaults; no clearing pass is needed.
`default_nettype none

module text_page_breaker #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                text_valid,
  output      logic                                text_stall,
  input  wire logic [7:0]                          text_byte,
  input  wire logic                                restart,
  output      logic                                page_valid,
  input  wire logic                                page_stall,
  output      logic [31:0]                         next_page_offset,
  output      logic [13:0]                         page_count,
  output      logic                                limit_reached,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [tpb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [tpb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import tpb_pkg::*;

  cfg_t        cfg;
  result_t     res;
  logic [13:0] pages_done;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_restart;
  logic        advance;

  tpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpb_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .text_byte  (s1_byte),
    .restart    (s1_restart),
    .cfg        (cfg),
    .res        (res),
    .pages_done (pages_done)
  );

  // The held byte moves on whenever the result register is free or draining.
  assign advance    = s1_valid && (!page_valid || !page_stall);
  assign text_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_valid && !text_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      s1_byte    <= text_byte;
      s1_restart <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= 1'b0;
    end else if (advance) begin
      page_valid <= res.valid;
    end else if (page_valid && !page_stall) begin
      page_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      next_page_offset <= res.next_page_offset;
      page_count       <= res.page_count;
      limit_reached    <= res.limit_reached;
    end
  end

  // A waiting result always carries the latest page count.
  assert property (@(posedge clk) disable iff (rst)
    page_valid |-> (page_count == pages_done))
    else $error("waiting result does not match the page count");

  // Taking the page that reaches the limit empties the result register.
  assert property (@(posedge clk) disable iff (rst)
    (page_valid && !page_stall && limit_reached) |=> !page_valid)
    else $error("result reported past the page limit");

  // The input side only stalls behind a blocked result.
  assert property (@(posedge clk) disable iff (rst)
    text_stall |-> (page_valid && page_stall))
    else $error("input stalled while the result register was free");

endmodule

`default_nettype wire

@@ dv/tpb_page_checker.sv @@
// ----------------------------------------------------------------------------
// tpb_page_checker
// Watches the text, page and register channels of the text page breaker,
// predicts every page report from the accepted bytes and compares each
// accepted report field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tpb_page_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               text_valid,
  input  logic                               text_stall,
  input  logic [7:0]                         text_byte,
  input  logic                               restart,
  input  logic                               page_valid,
  input  logic                               page_stall,
  input  logic [31:0]                        next_page_offset,
  input  logic [13:0]                        page_count,
  input  logic                               limit_reached,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [tpb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tpb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                 fail_count,
  output int                                 pages_waiting,
  output int                                 pages_predicted
);
  import tpb_pkg::*;

  typedef struct packed {
    logic [31:0] offset;
    logic [13:0] count;
    logic        at_limit;
  } page_rec_t;

  page_rec_t expected_pages[$];

  cfg_t        cfg;
  logic [9:0]  column;
  logic [5:0]  line_idx;
  logic [31:0] byte_ofs;
  logic        awaiting_trail;
  logic        swallow_next;
  logic        page_held;
  logic [13:0] pages_done;
  logic        byte_reported;

  function automatic void clear_layout();
    column         = '0;
    line_idx       = '0;
    byte_ofs       = '0;
    awaiting_trail = 1'b0;
    swallow_next   = 1'b0;
    page_held      = 1'b0;
  endfunction

  // Queues a report unless the page limit has already been met.
  function automatic void report_page();
    logic [13:0] lim;
    page_rec_t   rec;
    lim = (cfg.page_limit > PAGE_CAP) ? PAGE_CAP : cfg.page_limit;
    if (pages_done >= lim) return;
    pages_done   = pages_done + 14'd1;
    rec.offset   = byte_ofs;
    rec.count    = pages_done;
    rec.at_limit = (pages_done >= lim);
    expected_pages.push_back(rec);
  endfunction

  // Only one report can leave per byte; a second page end waits for the next.
  function automatic void end_page();
    if (byte_reported) begin
      page_held = 1'b1;
    end else begin
      byte_reported = 1'b1;
      report_page();
    end
  endfunction

  function automatic bit break_line();
    column   = '0;
    line_idx = line_idx + 6'd1;
    if (line_idx >= cfg.lines_per_page) begin
      line_idx = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_column(input logic [7:0] step);
    int unsigned next_col;
    next_col = 32'(column) + 32'(step);
    if (next_col > 32'(cfg.line_width)) begin
      if (break_line()) end_page();
    end else begin
      column = next_col[9:0];
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic rs);
    bit is_break;
    is_break      = (b == CHAR_CR) || (b == CHAR_LF);
    byte_reported = 1'b0;
    if (rs) clear_layout();

    // The second line end of a pair only moves the offset and releases a held page end.
    if (swallow_next && is_break) begin
      byte_ofs     = byte_ofs + 32'd1;
      swallow_next = 1'b0;
      if (page_held) begin
        page_held     = 1'b0;
        byte_reported = 1'b1;
        report_page();
      end
      return;
    end
    swallow_next = 1'b0;
    if (page_held) begin
      page_held     = 1'b0;
      byte_reported = 1'b1;
      report_page();
    end

    if (awaiting_trail) begin
      awaiting_trail = 1'b0;
      byte_ofs       = byte_ofs + 32'd1;
      advance_column(cfg.wide_advance);
      return;
    end

    if (column != '0 &&
        (32'(column) + 32'(cfg.break_slack)) > 32'(cfg.line_width)) begin
      if (break_line()) end_page();
    end

    byte_ofs = byte_ofs + 32'd1;
    if (b[WIDE_BIT]) begin
      awaiting_trail = 1'b1;
    end else if (is_break) begin
      swallow_next = 1'b1;
      if (break_line()) page_held = 1'b1;
    end else begin
      advance_column(cfg.narrow_advance);
    end
  endfunction

  always @(posedge clk) begin
    page_rec_t want;
    if (rst) begin
      cfg.line_width     = LINE_WIDTH_RESET;
      cfg.break_slack    = BREAK_SLACK_RESET;
      cfg.narrow_advance = NARROW_ADVANCE_RESET;
      cfg.wide_advance   = WIDE_ADVANCE_RESET;
      cfg.lines_per_page = LINES_PER_PAGE_RESET;
      cfg.page_limit     = PAGE_LIMIT_RESET;
      clear_layout();
      pages_done = '0;
      expected_pages.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINE_WIDTH:     cfg.line_width     = cfg_data[9:0];
          REG_BREAK_SLACK:    cfg.break_slack    = cfg_data[7:0];
          REG_NARROW_ADVANCE: cfg.narrow_advance = cfg_data[7:0];
          REG_WIDE_ADVANCE:   cfg.wide_advance   = cfg_data[7:0];
          REG_LINES_PER_PAGE: cfg.lines_per_page = cfg_data[5:0];
          REG_PAGE_LIMIT:     cfg.page_limit     = cfg_data[13:0];
          default: ;
        endcase
      end

      if (text_valid && !text_stall) predict_byte(text_byte, restart);

      if (page_valid && !page_stall) begin
        if (expected_pages.size() == 0) begin
          $error("unexpected page transaction: offset %0d, count %0d",
                 next_page_offset, page_count);
          fail_count++;
        end else begin
          want = expected_pages.pop_front();
          if (next_page_offset !== want.offset) begin
            $error("next_page_offset: expected %0d, actual %0d",
                   want.offset, next_page_offset);
            fail_count++;
          end
          if (page_count !== want.count) begin
            $error("page_count: expected %0d, actual %0d", want.count, page_count);
            fail_count++;
          end
          if (limit_reached !== want.at_limit) begin
            $error("limit_reached: expected %0b, actual %0b",
                   want.at_limit, limit_reached);
            fail_count++;
          end
        end
      end
    end
    pages_waiting   = expected_pages.size();
    pages_predicted = int'(pages_done);
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the text page breaker with directed and random text under a range of
// layout settings, with random idling on both channels, and reports the
// outcome of the page checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tpb_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      text_valid = 1'b0;
  logic                      text_stall;
  logic [7:0]                text_byte = '0;
  logic                      restart = 1'b0;
  logic                      page_valid;
  logic                      page_stall = 1'b0;
  logic [31:0]               next_page_offset;
  logic [13:0]               page_count;
  logic                      limit_reached;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int fail_count;
  int pages_waiting;
  int pages_predicted;
  int bytes_sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int mode_left  = 0;

  always #1 clk = ~clk;

  text_page_breaker dut (
    .clk              (clk),
    .rst              (rst),
    .text_valid       (text_valid),
    .text_stall       (text_stall),
    .text_byte        (text_byte),
    .restart          (restart),
    .page_valid       (page_valid),
    .page_stall       (page_stall),
    .next_page_offset (next_page_offset),
    .page_count       (page_count),
    .limit_reached    (limit_reached),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  tpb_page_checker page_checker (
    .clk              (clk),
    .rst              (rst),
    .text_valid       (text_valid),
    .text_stall       (text_stall),
    .text_byte        (text_byte),
    .restart          (restart),
    .page_valid       (page_valid),
    .page_stall       (page_stall),
    .next_page_offset (next_page_offset),
    .page_count       (page_count),
    .limit_reached    (limit_reached),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pages_waiting    (pages_waiting),
    .pages_predicted  (pages_predicted)
  );

  // Mostly short idles, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic int text_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 5) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  // The receiver switches between running free, light and heavy stalling.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      page_stall <= 1'b1;
    end else if (stall_mode != 0 &&
                 $urandom_range(0, 99) < (stall_mode == 1 ? 15 : 45)) begin
      stall_left = idle_length() - 1;
      page_stall <= 1'b1;
    end else begin
      page_stall <= 1'b0;
    end
  end

  task automatic send_text(input logic [7:0] b, input logic rs);
    int gap;
    gap = text_gap();
    @(negedge clk);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    restart    <= rs;
    do @(posedge clk); while (text_stall);
    bytes_sent++;
  endtask

  function automatic logic [7:0] line_end_char();
    return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
  endfunction

  // One piece of text: a narrow character, a whole wide character, a line
  // end that may be paired, or an arbitrary byte.
  task automatic send_text_piece();
    int   pick;
    logic rs;
    pick = $urandom_range(0, 99);
    rs   = ($urandom_range(0, 99) < 2);
    if (pick < 50) begin
      send_text(8'($urandom_range(8'h20, 8'h7E)), rs);
    end else if (pick < 66) begin
      send_text(8'h80 | 8'($urandom_range(0, 127)), rs);
      send_text(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 82) begin
      send_text(line_end_char(), rs);
      if ($urandom_range(0, 1)) send_text(line_end_char(), 1'b0);
    end else begin
      send_text(8'($urandom_range(0, 255)), rs);
    end
  endtask

  // Waits until every predicted report is out and the pipeline has emptied.
  task automatic drain_pages();
    @(negedge clk);
    text_valid <= 1'b0;
    while (pages_waiting != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [13:0] value, input int bits);
    logic [13:0] data;
    int          gap;
    data = value;
    if ($urandom_range(0, 1))
      data = value | (14'($urandom) & ~((14'd1 << bits) - 14'd1));
    gap = $urandom_range(0, 2);
    @(negedge clk);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic cfg_t make_setting(input int w, input int sl, input int na,
                                        input int wa, input int lpp, input int lim);
    cfg_t s;
    s.line_width     = 10'(w);
    s.break_slack    = 8'(sl);
    s.narrow_advance = 8'(na);
    s.wide_advance   = 8'(wa);
    s.lines_per_page = 6'(lpp);
    s.page_limit     = 14'(lim);
    return s;
  endfunction

  task automatic run_phase(input cfg_t s, input int n_bytes);
    int start;
    drain_pages();
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, '0, 0);
    write_reg(REG_LINE_WIDTH,     14'(s.line_width),     10);
    write_reg(REG_BREAK_SLACK,    14'(s.break_slack),     8);
    write_reg(REG_NARROW_ADVANCE, 14'(s.narrow_advance),  8);
    write_reg(REG_WIDE_ADVANCE,   14'(s.wide_advance),    8);
    write_reg(REG_LINES_PER_PAGE, 14'(s.lines_per_page),  6);
    write_reg(REG_PAGE_LIMIT,     s.page_limit,          14);
    @(negedge clk);
    cfg_valid <= 1'b0;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_text_piece();
  endtask

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int   rand_base;
    int   w, sl, na, wa, lpp, lim;
    int   extra;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Narrow characters wider than the line, so that a held page end and an
    // overflow can end two pages on the same byte.
    run_phase(make_setting(20, 5, 21, 15, 1, 9999), 0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(CHAR_CR, 1'b0);     // trail byte, not a line end
    send_text(8'h41, 1'b0);
    send_text(8'h42, 1'b0);
    send_text(CHAR_CR, 1'b0);
    send_text(CHAR_LF, 1'b0);
    send_text(CHAR_LF, 1'b0);
    send_text(CHAR_CR, 1'b0);
    send_text(CHAR_CR, 1'b0);
    send_text(8'h5A, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(CHAR_LF, 1'b0);
    send_text(8'hC3, 1'b0);
    send_text(8'h7E, 1'b1);       // restart drops the pending trail
    send_text(CHAR_CR, 1'b1);
    send_text(CHAR_CR, 1'b1);     // restart cancels the swallow
    send_text(8'h20, 1'b0);
    send_text(CHAR_LF, 1'b0);
    send_text(8'hFF, 1'b0);

    rand_base = pages_predicted;
    run_phase(make_setting(LINE_WIDTH_RESET, BREAK_SLACK_RESET, NARROW_ADVANCE_RESET,
                           WIDE_ADVANCE_RESET, LINES_PER_PAGE_RESET, PAGE_LIMIT_RESET),
              250);
    run_phase(make_setting(1, 0, 1, 1, 1, 9999), 150);
    run_phase(make_setting(1023, 255, 255, 255, 63, 16383), 120);
    run_phase(make_setting(20, 255, 5, 7, 3, 9999), 150);
    run_phase(make_setting(30, 4, 6, 9, 0, 9999), 150);
    run_phase(make_setting(0, 0, 1, 1, 2, 9999), 100);
    drain_pages();
    run_phase(make_setting(24, 3, 5, 8, 1, pages_predicted + 6), 150);
    run_phase(make_setting(24, 3, 5, 8, 1, 0), 80);

    repeat (5) begin
      drain_pages();
      w   = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(6, 80);
      sl  = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 12);
      na  = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 20);
      wa  = $urandom_range(1, 30);
      lpp = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 4);
      case ($urandom_range(0, 3))
        0, 1:    lim = 9999;
        2:       lim = 16383;
        default: lim = pages_predicted + $urandom_range(1, 30);
      endcase
      run_phase(make_setting(w, sl, na, wa, lpp, lim), 130);
    end

    // Keep going on short lines until enough pages have been reported, for at most five more phases.
    extra = 0;
    drain_pages();
    while (pages_predicted - rand_base < 48 && extra < 5) begin
      run_phase(make_setting(8, 0, 4, 4, 1, 16383), 100);
      drain_pages();
      extra++;
    end

    drain_pages();
    if (pages_waiting != 0) $error("%0d page results never arrived", pages_waiting);
    if (fail_count == 0 && pages_waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tpb_pkg.sv
rtl/tpb_cfg_regs.sv
rtl/tpb_core.sv
rtl/text_page_breaker.sv
dv/tpb_page_checker.sv
dv/tb.sv
